// File: rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared constants and byte class helpers for the hostname syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  // Register reset values
  localparam logic [7:0] MaxTotalRst = 8'd253;
  localparam logic [5:0] MaxLabelRst = 6'd63;

  // Register indexes on the configuration port
  localparam logic RegMaxTotal = 1'b0;
  localparam logic RegMaxLabel = 1'b1;

  // Counter widths and saturation points
  localparam int unsigned TotalW = 9;
  localparam int unsigned LabelW = 7;
  localparam logic [TotalW-1:0] TotalSat = '1;
  localparam logic [LabelW-1:0] LabelSat = '1;

  // ASCII codes
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = ((b >= ChLowA) && (b <= ChLowZ)) || ((b >= ChUpA) && (b <= ChUpZ));
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    is_numeral = (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

`default_nettype wire

// File: rtl/hostname_syntax_checker.sv
// ----------------------------------------------------------------------------
// hostname_syntax_checker
// Streaming RFC 1123 style hostname check, one byte per transaction.
// ----------------------------------------------------------------------------
// Bytes of a hostname arrive one per transaction, with is_last_i on the final
// byte; one name_valid_o verdict follows each final byte. Every byte goes through
// an input register and the label/length bookkeeping, so the block takes one
// byte per clock and registers a verdict once the final byte leaves the input
// register. Only a verdict waiting on a stalled output holds up the input. The
// user must set the limits (0x0: max total length, 0x4: max label length) over
// APB only while no name is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module hostname_syntax_checker
  import hsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        is_last_i,
  // verdict
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             name_valid_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    PH_START,
    PH_ALNUM,
    PH_HYPHEN,
    PH_DOT
  } phase_e;

  // Configuration registers
  logic [7:0] max_total_q;
  logic [5:0] max_label_q;
  logic       cfg_wr;
  logic       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= MaxTotalRst;
      max_label_q <= MaxLabelRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegMaxTotal: max_total_q <= pwdata[7:0];
        RegMaxLabel: max_label_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegMaxTotal: prdata = {24'd0, max_total_q};
      RegMaxLabel: prdata = {26'd0, max_label_q};
      default:     prdata = '0;
    endcase
  end

  // Input register
  logic       s1_vld_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       out_free;
  logic       s1_go;
  logic       in_acc;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_go      = s1_vld_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_vld_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= char_byte_i;
      s1_last_q <= is_last_i;
    end
  end

  // Name state
  phase_e            phase_q, phase_d;
  logic [LabelW-1:0] label_q, label_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              lbl_let_q, lbl_let_d;
  logic              name_let_q, name_let_d;
  logic              failed_q, failed_d;
  logic              out_vld_q, out_vld_d;
  logic              verdict_q, verdict_d;

  logic [LabelW-1:0] label_inc;
  logic [TotalW-1:0] total_inc;
  logic              b_dot, b_hyph, b_let, b_dig;
  logic              ok;

  always_comb begin
    b_dot  = (s1_char_q == ChDot);
    b_hyph = (s1_char_q == ChHyphen);
    b_let  = is_letter(s1_char_q);
    b_dig  = is_numeral(s1_char_q);

    total_inc = (total_q == TotalSat) ? total_q : total_q + TotalW'(1);
    label_inc = (label_q == LabelSat) ? label_q : label_q + LabelW'(1);

    phase_d    = phase_q;
    label_d    = label_q;
    total_d    = total_inc;
    lbl_let_d  = lbl_let_q;
    name_let_d = name_let_q;
    failed_d   = failed_q || (total_inc > {1'b0, max_total_q});

    if (b_dot) begin
      if (phase_q != PH_ALNUM) failed_d = 1'b1;
      lbl_let_d = 1'b0;
      phase_d   = PH_DOT;
      label_d   = '0;
    end else if (b_hyph || b_let || b_dig) begin
      if (b_hyph && (phase_q == PH_START || phase_q == PH_DOT)) failed_d = 1'b1;
      if (b_let) begin
        lbl_let_d  = 1'b1;
        name_let_d = 1'b1;
      end
      phase_d = b_hyph ? PH_HYPHEN : PH_ALNUM;
      label_d = label_inc;
      if (label_inc > {1'b0, max_label_q}) failed_d = 1'b1;
    end else begin
      failed_d = 1'b1;
    end

    // Final label must end on alnum or dot; an undotted last label needs a letter
    ok = !failed_d && (phase_d == PH_ALNUM || phase_d == PH_DOT) && name_let_d &&
         !(phase_d == PH_ALNUM && !lbl_let_d);

    out_vld_d = out_vld_q && !out_ready_i;
    verdict_d = verdict_q;
    if (s1_go && s1_last_q) begin
      out_vld_d = 1'b1;
      verdict_d = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      phase_q    <= PH_START;
      label_q    <= '0;
      total_q    <= '0;
      lbl_let_q  <= 1'b0;
      name_let_q <= 1'b0;
      failed_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      verdict_q  <= 1'b0;
    end else begin
      if (in_ready_o) s1_vld_q <= in_valid_i;
      out_vld_q <= out_vld_d;
      verdict_q <= verdict_d;
      if (s1_go) begin
        if (s1_last_q) begin
          phase_q    <= PH_START;
          label_q    <= '0;
          total_q    <= '0;
          lbl_let_q  <= 1'b0;
          name_let_q <= 1'b0;
          failed_q   <= 1'b0;
        end else begin
          phase_q    <= phase_d;
          label_q    <= label_d;
          total_q    <= total_d;
          lbl_let_q  <= lbl_let_d;
          name_let_q <= name_let_d;
          failed_q   <= failed_d;
        end
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign name_valid_o = verdict_q;

  // Assertions
  a_verdict_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> out_vld_q)
    else $error("no verdict after final byte");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> (total_q == '0) && (label_q == '0) && (phase_q == PH_START)
      && !failed_q)
    else $error("name state not cleared after verdict");

  a_label_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {2'b00, label_q} <= total_q)
    else $error("label count exceeds total count");

endmodule

`default_nettype wire

// File: bench/hostname_verdict_checker.sv
// ----------------------------------------------------------------------------
// hostname_verdict_checker
// Tracks the byte stream and the limit registers of the hostname syntax
// checker, works out the verdict of every name and compares it with the
// verdicts the block delivers. Register reads are checked against the
// reset or written limit values.
// ----------------------------------------------------------------------------
module hostname_verdict_checker
  import hsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_byte_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        name_valid_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LblStart,
    LblAlnum,
    LblHyphen,
    LblDot
  } label_phase_e;

  typedef enum logic [2:0] {
    KindLetter,
    KindDigit,
    KindHyphen,
    KindDot,
    KindOther
  } byte_kind_e;

  logic [7:0]   lim_total;
  logic [5:0]   lim_label;

  label_phase_e phase;
  logic [6:0]   lbl_cnt;
  logic [8:0]   tot_cnt;
  logic         lbl_alpha;
  logic         name_alpha;
  logic         failed;

  logic         verdicts[$];
  int           mismatches;
  logic         want;
  logic [31:0]  rd_want;

  function automatic byte_kind_e classify(input logic [7:0] b);
    if ((b >= ChLowA && b <= ChLowZ) || (b >= ChUpA && b <= ChUpZ)) return KindLetter;
    if (b >= ChZero && b <= ChNine) return KindDigit;
    if (b == ChHyphen) return KindHyphen;
    if (b == ChDot) return KindDot;
    return KindOther;
  endfunction

  task automatic forget_name();
    phase      = LblStart;
    lbl_cnt    = '0;
    tot_cnt    = '0;
    lbl_alpha  = 1'b0;
    name_alpha = 1'b0;
    failed     = 1'b0;
  endtask

  task automatic count_label_byte();
    if (lbl_cnt != LabelSat) lbl_cnt++;
    if (lbl_cnt > lim_label) failed = 1'b1;
  endtask

  // advance the name state by one byte; the final byte yields a verdict
  task automatic take_byte(input logic [7:0] b, input logic last);
    byte_kind_e kind;
    logic       ok;
    kind = classify(b);
    if (tot_cnt != TotalSat) tot_cnt++;
    if (tot_cnt > lim_total) failed = 1'b1;
    case (kind)
      KindDot: begin
        if (phase != LblAlnum) failed = 1'b1;
        lbl_alpha = 1'b0;
        phase     = LblDot;
        lbl_cnt   = '0;
      end
      KindHyphen: begin
        if (phase == LblStart || phase == LblDot) failed = 1'b1;
        phase = LblHyphen;
        count_label_byte();
      end
      KindLetter, KindDigit: begin
        if (kind == KindLetter) begin
          lbl_alpha  = 1'b1;
          name_alpha = 1'b1;
        end
        phase = LblAlnum;
        count_label_byte();
      end
      default: failed = 1'b1;
    endcase
    if (last) begin
      ok = !failed && (phase == LblAlnum || phase == LblDot) && name_alpha;
      // an undotted final label made of digits only is rejected
      if (phase == LblAlnum && !lbl_alpha) ok = 1'b0;
      verdicts.push_back(ok);
      forget_name();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forget_name();
      lim_total  = MaxTotalRst;
      lim_label  = MaxLabelRst;
      verdicts.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == RegMaxTotal) lim_total = pwdata[7:0];
          else if (paddr[2] == RegMaxLabel) lim_label = pwdata[5:0];
        end else begin
          rd_want = (paddr[2] == RegMaxTotal) ? {24'd0, lim_total} : {26'd0, lim_label};
          if (prdata !== rd_want) begin
            $error("prdata: expected %0h, got %0h", rd_want, prdata);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) take_byte(char_byte_i, is_last_i);
      if (out_valid_i && out_ready_i) begin
        if (verdicts.size() == 0) begin
          $error("name_valid: expected no transaction, got %0b", name_valid_i);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          if (name_valid_i !== want) begin
            $error("name_valid: expected %0b, got %0b", want, name_valid_i);
            mismatches++;
          end
        end
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= verdicts.size();
    end
  end

endmodule

// File: bench/tb_hostname_syntax_checker.sv
// ----------------------------------------------------------------------------
// tb_hostname_syntax_checker
// Feeds hostnames byte by byte under several limit settings: a directed set
// of corner cases, names at the label and total length limits, then random
// well-formed, broken and noise names, with random stalls on both channels
// and one long output stall. Verdicts are checked by
// hostname_verdict_checker.
// ----------------------------------------------------------------------------
module tb_hostname_syntax_checker;
  import hsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases     = 7;
  localparam int PhaseBytes    = 50;
  localparam int PhaseNames    = 4;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  char_byte = '0;
  logic        is_last   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        name_valid;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;

  int          send_idle = 0;
  int          recv_idle = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet     = 0;

  int          cur_total = MaxTotalRst;
  int          cur_label = MaxLabelRst;
  int          phase_bytes;
  int          phase_names;
  logic [7:0]  name_q[$];

  string samples[15] = '{"a", "Z9", "0", "a.1", "1.z", "x.", ".", "-a", "a-", "a--b",
                         ".a", "a..b", "a-.b", "a.-b", "!bc"};

  always #5 clk_i = ~clk_i;

  hostname_syntax_checker i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_byte_i  (char_byte),
    .is_last_i    (is_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .name_valid_o (name_valid),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  hostname_verdict_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .char_byte_i    (char_byte),
    .is_last_i      (is_last),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .name_valid_i   (name_valid),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .mismatch_cnt_o (mismatches),
    .pending_o      (outstanding)
  );

  // verdict receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WatchdogLimit) begin
        $display("hostname_syntax_checker test failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    char_byte <= b;
    is_last   <= last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_byte(name_q[i], i == name_q.size() - 1);
    phase_bytes += name_q.size();
    phase_names++;
  endtask

  task automatic send_text(input string s);
    name_q.delete();
    for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
    send_name();
  endtask

  // stop offering bytes and let every verdict arrive
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic idx, input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_limits(input int total, input int label);
    cur_total = total;
    cur_label = label;
    reg_access(RegMaxTotal, 1'b1, 32'(total));
    reg_access(RegMaxLabel, 1'b1, 32'(label));
    reg_access(RegMaxTotal, 1'b0, '0);
    reg_access(RegMaxLabel, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(1)) return 8'(ChLowA + $urandom_range(25));
    return 8'(ChUpA + $urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(9) < 7) return pick_letter();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  // well-formed label holding at least one letter
  task automatic add_label(input int len);
    int         spot;
    logic [7:0] c;
    spot = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (i == spot) c = pick_letter();
      else if (i == 0 || i == len - 1) c = pick_alnum();
      else c = ($urandom_range(5) == 0) ? ChHyphen : pick_alnum();
      name_q.push_back(c);
    end
  endtask

  task automatic send_chain(input int count, input int len, input int tail);
    name_q.delete();
    repeat (count) begin
      add_label(len);
      name_q.push_back(ChDot);
    end
    add_label(tail);
    send_name();
  endtask

  task automatic make_random_name();
    int kind;
    int labels;
    int len;
    int cap;
    int pos;
    name_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(1, 8);
      repeat (len) name_q.push_back(8'($urandom_range(255)));
      return;
    end
    cap    = (cur_label < 1) ? 1 : cur_label;
    labels = $urandom_range(1, 4);
    for (int n = 0; n < labels; n++) begin
      if (n != 0) name_q.push_back(ChDot);
      case ($urandom_range(9))
        0:       len = cap;
        1:       len = cap + 1;
        default: len = $urandom_range(1, (cap < 8) ? cap : 8);
      endcase
      add_label(len);
    end
    if ($urandom_range(3) == 0) name_q.push_back(ChDot);
    if (kind < 65) return;
    pos = $urandom_range(name_q.size() - 1);
    case ($urandom_range(5))
      0: name_q[pos] = 8'($urandom_range(255));
      1: name_q.push_front(ChDot);
      2: name_q.insert(pos, ChDot);
      3: name_q.insert(pos, ChHyphen);
      4: begin
        // final undotted label of digits only
        if (name_q[$] != ChDot) name_q.push_back(ChDot);
        repeat ($urandom_range(1, 3)) name_q.push_back(8'(ChZero + $urandom_range(9)));
      end
      default: name_q[name_q.size() - 1] = ChHyphen;
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph < 3) begin
        send_idle = 36;
        recv_idle <= 67;
      end else if (ph < 5) begin
        send_idle = 67;
        recv_idle <= 36;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      case (ph)
        0: begin
          reg_access(RegMaxTotal, 1'b0, '0);
          reg_access(RegMaxLabel, 1'b0, '0);
        end
        1: program_limits(255, 63);
        2: program_limits(1, 1);
        3: program_limits(0, 0);
        4: program_limits(20, 4);
        5: program_limits(29, 8);
        default: program_limits($urandom_range(1, 255), $urandom_range(1, 63));
      endcase
      phase_bytes = 0;
      phase_names = 0;

      case (ph)
        0: begin
          foreach (samples[i]) send_text(samples[i]);
          name_q = '{8'h00};
          send_name();
          name_q = '{8'hFF};
          send_name();
        end
        1: begin
          hold_req <= 1'b1;
          // second name's last byte waits on the held verdict and blocks input
          send_text("ab");
          send_text("cd");
          send_chain(0, 0, 63);
          send_chain(0, 0, 64);
        end
        2: begin
          send_text("a");
          send_text("ab");
        end
        5: begin
          send_chain(3, 8, 2);     // exactly the total limit
          send_chain(3, 8, 3);     // one byte over
        end
        default: ;
      endcase

      while (phase_bytes < PhaseBytes || phase_names < PhaseNames) begin
        make_random_name();
        send_name();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("hostname_syntax_checker test passed");
    end else begin
      $display("hostname_syntax_checker test failed");
    end
    $finish;
  end

endmodule
